FILE: rtl/framed_command_packet_receiver_defines.svh
// Assertion helpers used by the top-level receiver RTL.
`ifndef FRAMED_COMMAND_PACKET_RECEIVER_DEFINES_SVH
`define FRAMED_COMMAND_PACKET_RECEIVER_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication: cons must hold whenever ante holds.
`define FCPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fcpr same-cycle check failed");
// Next-cycle implication: cons must hold in the cycle after ante.
`define FCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcpr next-cycle check failed");
`else
`define FCPR_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FCPR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: rtl/fcpr_pkg.sv
package fcpr_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_INDEX_W = 2;

	// Register indexes of the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_START_MARKER = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_END_MARKER   = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MANUAL_MODE  = 2'd2;

	localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd2;
	localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd3;
	localparam logic [BYTE_W-1:0] MANUAL_MODE_RST  = 8'd0;

	// Packet positions that are kept; later payload positions are ignored
	localparam int unsigned POS_START       = 0;
	localparam int unsigned POS_MODE        = 1;
	localparam int unsigned POS_LEFT_DIR    = 2;
	localparam int unsigned POS_LEFT_SPEED  = 3;
	localparam int unsigned POS_RIGHT_DIR   = 4;
	localparam int unsigned POS_RIGHT_SPEED = 5;
	localparam int unsigned POS_GAIN_P      = 6;
	localparam int unsigned POS_GAIN_I      = 7;
	localparam int unsigned POS_GAIN_D      = 8;
	localparam int unsigned STORED_BYTES    = 9;

	localparam int unsigned RESULT_W = 8 * BYTE_W + 1;
	localparam int unsigned RESULT_BYTES = (RESULT_W + 7) / 8;
	localparam int unsigned M_TDATA_W = RESULT_BYTES * 8;

	typedef struct packed {
		logic [BYTE_W-1:0] start_marker;
		logic [BYTE_W-1:0] end_marker;
		logic [BYTE_W-1:0] manual_mode_code;
	} cfg_t;

	typedef struct packed {
		logic              straight;
		logic [BYTE_W-1:0] gain_d;
		logic [BYTE_W-1:0] gain_i;
		logic [BYTE_W-1:0] gain_p;
		logic [BYTE_W-1:0] right_speed;
		logic [BYTE_W-1:0] right_dir;
		logic [BYTE_W-1:0] left_speed;
		logic [BYTE_W-1:0] left_dir;
		logic [BYTE_W-1:0] mode;
	} result_t;

	typedef struct packed {
		logic last_pos;       // next accepted byte closes the packet
		logic straight_hold;  // straight flag held from earlier packets
	} stat_t;

endpackage

FILE: rtl/fcpr_cfg_regs.sv
module fcpr_cfg_regs (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fcpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fcpr_pkg::BYTE_W-1:0]         cfg_data,
	output fcpr_pkg::cfg_t                      cfg
);
	import fcpr_pkg::*;

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_marker     <= START_MARKER_RST;
			cfg_q.end_marker       <= END_MARKER_RST;
			cfg_q.manual_mode_code <= MANUAL_MODE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_START_MARKER: cfg_q.start_marker     <= cfg_data;
				REG_END_MARKER:   cfg_q.end_marker       <= cfg_data;
				REG_MANUAL_MODE:  cfg_q.manual_mode_code <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

FILE: rtl/fcpr_collect.sv
module fcpr_collect #(
	parameter int unsigned PACKET_BYTES = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_accept,
	input  logic [fcpr_pkg::BYTE_W-1:0] in_byte,
	input  fcpr_pkg::cfg_t              cfg,
	output logic                        res_valid,
	output fcpr_pkg::result_t           res,
	output fcpr_pkg::stat_t             stat
);
	import fcpr_pkg::*;

	localparam int unsigned CW = $clog2(PACKET_BYTES);
	localparam logic [CW-1:0] LAST = CW'(PACKET_BYTES - 1);

	logic [CW-1:0]     count_q;
	logic [BYTE_W-1:0] pkt_q [STORED_BYTES];
	logic              straight_q;

	logic open_pkt;
	logic advance;
	logic closing;
	logic good;
	logic straight_eq;
	logic straight_next;

	assign open_pkt = in_accept && (count_q == '0) && (in_byte == cfg.start_marker);
	assign advance  = open_pkt || (in_accept && (count_q != '0));
	assign closing  = advance && (count_q == LAST);
	assign good     = closing && (pkt_q[POS_START] == cfg.start_marker)
		&& (in_byte == cfg.end_marker);

	assign straight_eq = (pkt_q[POS_LEFT_DIR] == pkt_q[POS_RIGHT_DIR])
		&& (pkt_q[POS_LEFT_SPEED] == pkt_q[POS_RIGHT_SPEED])
		&& (pkt_q[POS_LEFT_SPEED] != '0);
	assign straight_next = (pkt_q[POS_MODE] == cfg.manual_mode_code) ? straight_eq : straight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			straight_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q <= (count_q == LAST) ? '0 : count_q + 1'b1;
			end
			if (good) begin
				straight_q <= straight_next;
			end
		end
	end

	// Byte store: each kept position loads at its own count value
	for (genvar k = 0; k < STORED_BYTES; k++) begin : g_store
		always_ff @(posedge clk) begin
			if (advance && (count_q == CW'(k))) begin
				pkt_q[k] <= in_byte;
			end
		end
	end

	assign res_valid       = good;
	assign res.mode        = pkt_q[POS_MODE];
	assign res.left_dir    = pkt_q[POS_LEFT_DIR];
	assign res.left_speed  = pkt_q[POS_LEFT_SPEED];
	assign res.right_dir   = pkt_q[POS_RIGHT_DIR];
	assign res.right_speed = pkt_q[POS_RIGHT_SPEED];
	assign res.gain_p      = pkt_q[POS_GAIN_P];
	assign res.gain_i      = pkt_q[POS_GAIN_I];
	assign res.gain_d      = pkt_q[POS_GAIN_D];
	assign res.straight    = straight_next;

	assign stat.last_pos      = (count_q == LAST);
	assign stat.straight_hold = straight_q;

endmodule

FILE: rtl/framed_command_packet_receiver.sv
// Framed command packet receiver. Bytes arrive one word per cycle on the
// s_axis channel. While idle the block drops every byte that differs from
// the start marker; a start byte opens a packet of PACKET_BYTES bytes, and
// the following bytes are collected without resync. When the closing byte
// arrives the packet is kept only if its first byte still equals the start
// marker and its closing byte equals the end marker; otherwise it is dropped
// silently. A kept packet yields one word on m_axis, in the cycle after the
// closing byte: mode, both wheel directions and speeds, the three gain bytes
// and the straight flag. The straight flag is recomputed only when the mode
// byte equals the manual mode code (same directions, same nonzero speed) and
// holds its value otherwise. Rate: one byte per cycle, save for stalls: the
// input stalls only when a closing byte meets an output register still
// holding an unclaimed result; the single output register sets that limit.
// Write the configuration registers only while no packet is in flight.
`include "framed_command_packet_receiver_defines.svh"

module framed_command_packet_receiver #(
	parameter int unsigned PACKET_BYTES = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// received bytes
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [fcpr_pkg::BYTE_W-1:0]         s_axis_tdata,   // [7:0] rx_byte
	// decoded commands
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [7:0] mode, [15:8] left_dir, [23:16] left_speed, [31:24] right_dir,
	// [39:32] right_speed, [47:40] gain_p, [55:48] gain_i, [63:56] gain_d,
	// [64] straight, [71:65] zero
	output logic [fcpr_pkg::M_TDATA_W-1:0]      m_axis_tdata,
	// configuration writes
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fcpr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fcpr_pkg::BYTE_W-1:0]         cfg_data
);
	import fcpr_pkg::*;

	cfg_t    cfg;
	result_t res;
	stat_t   stat;
	logic    res_valid;
	logic    in_accept;

	logic    out_valid_q;
	result_t out_q;

	fcpr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fcpr_collect #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_collect (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_accept (in_accept),
		.in_byte   (s_axis_tdata),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res),
		.stat      (stat)
	);

	// Only the closing byte can produce a result, so hold the input just
	// when that byte would land on an unclaimed output word.
	assign s_axis_tready = !out_valid_q || m_axis_tready || !stat.last_pos;
	assign in_accept     = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload: load on a kept packet, otherwise hold
	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(M_TDATA_W - RESULT_W){1'b0}}, out_q};

	// A waiting result is never overwritten by a new one.
	`FCPR_ASSERT_NOW(a_no_overwrite, clk, arst_n, out_valid_q && !m_axis_tready, !res_valid)
	// A kept packet is always presented on the next cycle.
	`FCPR_ASSERT_NEXT(a_result_shown, clk, arst_n, res_valid, m_axis_tvalid)
	// Results only come out of a closing byte.
	`FCPR_ASSERT_NOW(a_result_on_close, clk, arst_n, res_valid, in_accept && stat.last_pos)
	// Outside manual mode the straight flag keeps the held value.
	`FCPR_ASSERT_NOW(a_straight_held, clk, arst_n,
		res_valid && (res.mode != cfg.manual_mode_code), res.straight == stat.straight_hold)

endmodule
